### rtl/core/apk_pkg.sv
// Shared types and constants for the average precision at k block.
`timescale 1ns / 1ps
package apk_pkg;

  localparam int unsigned ScoreW  = 32;
  localparam int unsigned KW      = 11;
  localparam int unsigned ApW     = 17;
  localparam int unsigned FoundW  = 11;
  localparam int unsigned FracW   = 16;
  localparam logic [ScoreW-1:0] SignFlip = 32'h8000_0000;
  localparam logic [ApW-1:0]    ApOne    = 17'h10000;
  localparam logic [31:0]       SumMax   = 32'hFFFF_FFFF;

  typedef struct packed {
    logic signed [ScoreW-1:0] score;
    logic                     relevant;
    logic                     last_sample;
  } in_t;

  typedef struct packed {
    logic [ApW-1:0]    average_precision;
    logic [FoundW-1:0] relevant_found;
  } out_t;

  typedef enum logic [13:0] {
    ST_IDLE      = 14'b00000000000001,
    ST_SETUP     = 14'b00000000000010,
    ST_RK_READ   = 14'b00000000000100,
    ST_RK_WAIT   = 14'b00000000001000,
    ST_SCAN      = 14'b00000000010000,
    ST_INS_CHK   = 14'b00000000100000,
    ST_INS_CMP   = 14'b00000001000000,
    ST_INS_PUT   = 14'b00000010000000,
    ST_SUM_READ  = 14'b00000100000000,
    ST_SUM_WAIT  = 14'b00001000000000,
    ST_SUM_DIV   = 14'b00010000000000,
    ST_AVG_START = 14'b00100000000000,
    ST_AVG_DIV   = 14'b01000000000000,
    ST_OUT       = 14'b10000000000000
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load_en;
    logic setup;
    logic zero_res;
    logic rk_read;
    logic rk_latch;
    logic rk_skip;
    logic scan;
    logic ins_init;
    logic ins_read;
    logic ins_shift;
    logic ins_put;
    logic sum_init;
    logic sum_read;
    logic div_term;
    logic sum_acc;
    logic div_avg;
    logic avg_latch;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last_acc;
    logic no_rel;
    logic i_end;
    logic rel_bit;
    logic scan_done;
    logic pos_zero;
    logic gt;
    logic lim_end;
    logic rank_ge_k;
    logic div_done;
    logic out_free;
  } sta_t;

endpackage

### rtl/core/apk_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module apk_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### rtl/core/apk_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module apk_div #(
  parameter int unsigned NW = 32,
  parameter int unsigned DW = 11
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [NW-1:0] quo_o
);

  localparam int unsigned CNTW = $clog2(NW + 1);

  logic [NW-1:0]   quo_q;
  logic [DW-1:0]   rem_q, den_q;
  logic [CNTW-1:0] cnt_q;
  logic            busy_q, done_q;
  logic [DW:0]     shifted, diff;

  assign shifted = {rem_q, quo_q[NW-1]};
  assign diff    = shifted - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CNTW'(NW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + CNTW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      if (!diff[DW]) begin
        rem_q <= diff[DW-1:0];
        quo_q <= {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_q <= shifted[DW-1:0];
        quo_q <= {quo_q[NW-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

### rtl/core/apk_dp.sv
// Datapath: sample and rank stores, rank counter, insertion sort, sum and divide.
`timescale 1ns / 1ps
module apk_dp #(
  parameter int unsigned MAX_SAMPLES = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  apk_pkg::in_t               in_data_i,
  input  logic                       cfg_we_i,
  input  logic [apk_pkg::KW-1:0]     cfg_wdata_i,
  input  apk_pkg::cmd_t              cmd_i,
  output apk_pkg::sta_t              sta_o,
  input  logic                       out_stall_i,
  output logic                       out_valid_o,
  output apk_pkg::out_t              out_data_o
);
  import apk_pkg::*;

  localparam int unsigned AW   = $clog2(MAX_SAMPLES);
  localparam int unsigned CW   = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned DVW  = (CW + FracW > 32) ? CW + FracW : 32;
  localparam int unsigned SW   = DVW + 1;
  localparam int unsigned CMPW = (CW > KW) ? CW : KW;

  logic [KW-1:0]     cut_q;
  logic [CW-1:0]     cnt_q, relc_q, k_q, lim_q, i_q, j_q, pj_q;
  logic [CW-1:0]     higher_q, equal_q, filled_q, pos_q;
  logic              pend_q;
  logic [ScoreW-1:0] me_q;
  logic [AW-1:0]     r_q;
  logic [31:0]       sum_q;
  logic [ApW-1:0]    res_q;
  logic              out_valid_q;
  out_t              out_q;

  logic              accept, store_en;
  logic [ScoreW:0]   sc_rd;
  logic [AW-1:0]     sc_raddr;
  logic              rk_we;
  logic [AW-1:0]     rk_waddr, rk_raddr;
  logic [AW-1:0]     rk_wdata, rk_rd;
  logic              div_start, div_done;
  logic [DVW-1:0]    div_num, div_quo;
  logic [CW-1:0]     div_den;
  logic [CW-1:0]     k_new;
  logic [SW-1:0]     acc;

  assign accept   = in_valid_i && cmd_i.load_en;
  assign store_en = accept && (cnt_q < CW'(MAX_SAMPLES));
  assign sc_raddr = cmd_i.scan ? j_q[AW-1:0] : i_q[AW-1:0];

  apk_ram #(.Width(ScoreW + 1), .Depth(MAX_SAMPLES)) u_score_ram (
    .clk_i   (clk_i),
    .we_i    (store_en),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i ({in_data_i.relevant, in_data_i.score ^ SignFlip}),
    .raddr_i (sc_raddr),
    .rdata_o (sc_rd)
  );

  assign rk_we    = cmd_i.ins_shift || cmd_i.ins_put;
  assign rk_waddr = pos_q[AW-1:0];
  assign rk_wdata = cmd_i.ins_shift ? rk_rd : r_q;
  assign rk_raddr = cmd_i.ins_read ? AW'(pos_q - CW'(1)) : i_q[AW-1:0];

  apk_ram #(.Width(AW), .Depth(MAX_SAMPLES)) u_rank_ram (
    .clk_i   (clk_i),
    .we_i    (rk_we),
    .waddr_i (rk_waddr),
    .wdata_i (rk_wdata),
    .raddr_i (rk_raddr),
    .rdata_o (rk_rd)
  );

  assign div_start = cmd_i.div_term || cmd_i.div_avg;
  assign div_num   = cmd_i.div_avg ? DVW'(sum_q) : (DVW'(i_q + CW'(1)) << FracW);
  assign div_den   = cmd_i.div_avg ? lim_q : (CW'(rk_rd) + CW'(1));

  apk_div #(.NW(DVW), .DW(CW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // zero or past the list length means the whole list
  assign k_new = ((cut_q == '0) || (CMPW'(cut_q) > CMPW'(cnt_q))) ? cnt_q : CW'(cut_q);
  assign acc   = SW'(sum_q) + SW'(div_quo);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cut_q       <= '0;
      cnt_q       <= '0;
      relc_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cut_q <= cfg_wdata_i;
      end
      if (store_en) begin
        cnt_q  <= cnt_q + CW'(1);
        relc_q <= relc_q + CW'(in_data_i.relevant);
      end
      if (cmd_i.rk_latch) begin
        pend_q <= 1'b0;
      end else if (cmd_i.scan) begin
        pend_q <= (j_q != cnt_q);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
        cnt_q       <= '0;
        relc_q      <= '0;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      k_q      <= k_new;
      lim_q    <= (relc_q < k_new) ? relc_q : k_new;
      i_q      <= '0;
      filled_q <= '0;
    end
    if (cmd_i.zero_res) begin
      res_q <= '0;
    end
    if (cmd_i.rk_skip) begin
      i_q <= i_q + CW'(1);
    end
    if (cmd_i.rk_latch) begin
      me_q     <= sc_rd[ScoreW-1:0];
      j_q      <= '0;
      higher_q <= '0;
      equal_q  <= '0;
    end
    if (cmd_i.scan) begin
      if (j_q != cnt_q) begin
        pj_q <= j_q;
        j_q  <= j_q + CW'(1);
      end
      if (pend_q && (pj_q != i_q)) begin
        if (sc_rd[ScoreW-1:0] > me_q) begin
          higher_q <= higher_q + CW'(1);
        end else if (sc_rd[ScoreW-1:0] == me_q) begin
          equal_q <= equal_q + CW'(1);
        end
      end
    end
    if (cmd_i.ins_init) begin
      pos_q <= filled_q;
      r_q   <= AW'(higher_q + (equal_q >> 1));
    end
    if (cmd_i.ins_shift) begin
      pos_q <= pos_q - CW'(1);
    end
    if (cmd_i.ins_put) begin
      filled_q <= filled_q + CW'(1);
      i_q      <= i_q + CW'(1);
    end
    if (cmd_i.sum_init) begin
      i_q   <= '0;
      sum_q <= '0;
    end
    if (cmd_i.sum_acc) begin
      sum_q <= (|acc[SW-1:32]) ? SumMax : acc[31:0];
      i_q   <= i_q + CW'(1);
    end
    if (cmd_i.avg_latch) begin
      res_q <= (div_quo > DVW'(ApOne)) ? ApOne : div_quo[ApW-1:0];
    end
    if (cmd_i.out_load) begin
      out_q.average_precision <= res_q;
      out_q.relevant_found    <= FoundW'(relc_q);
    end
  end

  assign sta_o.last_acc  = accept && in_data_i.last_sample;
  assign sta_o.no_rel    = (relc_q == '0);
  assign sta_o.i_end     = (i_q == cnt_q);
  assign sta_o.rel_bit   = sc_rd[ScoreW];
  assign sta_o.scan_done = (j_q == cnt_q) && !pend_q;
  assign sta_o.pos_zero  = (pos_q == '0);
  assign sta_o.gt        = (rk_rd > r_q);
  assign sta_o.lim_end   = (i_q == lim_q);
  assign sta_o.rank_ge_k = (CW'(rk_rd) >= k_q);
  assign sta_o.div_done  = div_done;
  assign sta_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### rtl/core/apk_ctrl.sv
// Controller: sequences load, ranking, insertion sort, summation and result.
`timescale 1ns / 1ps
module apk_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  apk_pkg::sta_t sta_i,
  output apk_pkg::cmd_t cmd_o
);
  import apk_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.load_en = 1'b1;
        if (sta_i.last_acc) state_d = ST_SETUP;
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        if (sta_i.no_rel) begin
          cmd_o.zero_res = 1'b1;
          state_d        = ST_OUT;
        end else begin
          state_d = ST_RK_READ;
        end
      end
      ST_RK_READ: begin
        if (sta_i.i_end) begin
          cmd_o.sum_init = 1'b1;
          state_d        = ST_SUM_READ;
        end else begin
          cmd_o.rk_read = 1'b1;
          state_d       = ST_RK_WAIT;
        end
      end
      ST_RK_WAIT: begin
        if (sta_i.rel_bit) begin
          cmd_o.rk_latch = 1'b1;
          state_d        = ST_SCAN;
        end else begin
          cmd_o.rk_skip = 1'b1;
          state_d       = ST_RK_READ;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sta_i.scan_done) begin
          cmd_o.ins_init = 1'b1;
          state_d        = ST_INS_CHK;
        end
      end
      ST_INS_CHK: begin
        if (sta_i.pos_zero) begin
          state_d = ST_INS_PUT;
        end else begin
          cmd_o.ins_read = 1'b1;
          state_d        = ST_INS_CMP;
        end
      end
      ST_INS_CMP: begin
        if (sta_i.gt) begin
          cmd_o.ins_shift = 1'b1;
          state_d         = ST_INS_CHK;
        end else begin
          state_d = ST_INS_PUT;
        end
      end
      ST_INS_PUT: begin
        cmd_o.ins_put = 1'b1;
        state_d       = ST_RK_READ;
      end
      ST_SUM_READ: begin
        if (sta_i.lim_end) begin
          state_d = ST_AVG_START;
        end else begin
          cmd_o.sum_read = 1'b1;
          state_d        = ST_SUM_WAIT;
        end
      end
      ST_SUM_WAIT: begin
        // sorted ranks: the first one past the cut-off ends the sum
        if (sta_i.rank_ge_k) begin
          state_d = ST_AVG_START;
        end else begin
          cmd_o.div_term = 1'b1;
          state_d        = ST_SUM_DIV;
        end
      end
      ST_SUM_DIV: begin
        if (sta_i.div_done) begin
          cmd_o.sum_acc = 1'b1;
          state_d       = ST_SUM_READ;
        end
      end
      ST_AVG_START: begin
        cmd_o.div_avg = 1'b1;
        state_d       = ST_AVG_DIV;
      end
      ST_AVG_DIV: begin
        if (sta_i.div_done) begin
          cmd_o.avg_latch = 1'b1;
          state_d         = ST_OUT;
        end
      end
      ST_OUT: begin
        if (sta_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

### rtl/core/average_precision_at_k.sv
// Load: one sample per cycle, back to back, until the closing transaction.
// Close, n = samples held: each irrelevant sample is read and skipped; each relevant sample
// is read, ranked by a scan of all n scores and put into the sorted list, moving each larger entry.
// Sum: one divide per term on the 32-step divider, then one more divide for the mean.
// Ranking runs one score compare a cycle over the single-read score store.
// Reset clears the sample and relevant counts, cut-off and output valid; stores are not cleared.
`timescale 1ns / 1ps
module average_precision_at_k #(
  parameter int unsigned MAX_SAMPLES = 1024
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  apk_pkg::in_t           in_data_i,
  input  logic                   cfg_we_i,
  input  logic [apk_pkg::KW-1:0] cfg_wdata_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output apk_pkg::out_t          out_data_o
);
  import apk_pkg::*;

  cmd_t cmd;
  sta_t sta;

  apk_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sta_i  (sta),
    .cmd_o  (cmd)
  );

  apk_dp #(.MAX_SAMPLES(MAX_SAMPLES)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .sta_o       (sta),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  assign in_stall_o = !cmd.load_en;

  a_ap_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.average_precision <= ApOne))
    else $error("average precision above one");

  a_close_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_data_i.last_sample) |=> in_stall_o)
    else $error("input not stalled after closing transaction");

  a_none_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (MAX_SAMPLES < 2048 && out_valid_o && out_data_o.relevant_found == '0)
      |-> (out_data_o.average_precision == '0))
    else $error("nonzero precision with no relevant sample");

endmodule
